/* rtl/mat_pkg.sv */
// shared types, constants and helpers for the metropolis acceptance tracker
package mat_pkg;

    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_SCORE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_KT          = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWEST_ENERGY   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_INTERVAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ACCEPTED = 3'd4;

    localparam logic [31:0] INV_KT_RESET          = 32'd65536;
    localparam logic [31:0] REPORT_INTERVAL_RESET = 32'd10000;

    // exp(-1) in Q0.32
    localparam logic [31:0] EXP_M1_Q32   = 32'd1580030169;
    localparam logic [3:0]  SERIES_TERMS = 4'd13;
    localparam logic [23:0] MAX_INT_PART = 24'd17;

    typedef struct packed {
        logic signed [31:0] proposed_score;
        logic [23:0]        rand_fraction;
    } mat_in_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] current_score;
        logic [31:0]        step_total;
        logic [31:0]        accept_total;
        logic [31:0]        bound_total;
        logic signed [63:0] energy_sum;
        logic               report;
        logic               done_res;
    } mat_out_t;

    typedef struct packed {
        logic        start;
        logic [31:0] delta;
    } mat_exp_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] prob;
    } mat_exp_stat_t;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_DIFF,
        TOP_EXP,
        TOP_DEC
    } mat_top_state_t;

    typedef enum logic [3:0] {
        EXP_IDLE,
        EXP_XMUL,
        EXP_TERM,
        EXP_V,
        EXP_Q,
        EXP_C,
        EXP_POWM,
        EXP_POWR,
        EXP_DONE
    } mat_exp_state_t;

    // floor(2^32 / k), used to divide a series term by k
    function automatic logic [32:0] recip_q32(input logic [3:0] k);
        logic [32:0] r;
        case (k)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            4'd13:   r = 33'd330382099;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

/* rtl/mat_mul_unit.sv */
// shared unsigned multiplier with a registered product
module mat_mul_unit (
    input  logic        aclk,
    input  logic [32:0] op_a,
    input  logic [31:0] op_b,
    output logic [64:0] prod_reg
);

    logic [64:0] prod_next;

    assign prod_next = 65'(op_a) * 65'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

/* rtl/mat_exp_engine.sv */
// fixed point exp(-delta * inv_kt) in Q1.32 on one shared multiplier
module mat_exp_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mat_pkg::mat_exp_req_t  req,
    input  logic [23:0]            inv_kt,
    output mat_pkg::mat_exp_stat_t stat
);

    mat_pkg::mat_exp_state_t state_reg, state_next;

    logic [31:0]        f_reg, f_next;
    logic [4:0]         n_reg, n_next;
    logic [32:0]        t_reg, t_next;
    logic signed [33:0] sum_reg, sum_next;
    logic [3:0]         k_reg, k_next;
    logic [31:0]        v_reg, v_next;
    logic [31:0]        q_reg, q_next;
    logic [32:0]        p_reg, p_next;

    logic [32:0] op_a;
    logic [31:0] op_b;
    logic [64:0] prod_reg;

    logic [31:0]        rem;
    logic [32:0]        t_new;
    logic signed [33:0] sum_new;

    mat_mul_unit u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // remainder of the reciprocal quotient, at most one correction needed
    assign rem     = v_reg - prod_reg[31:0];
    assign t_new   = (rem >= {28'd0, k_reg}) ? ({1'b0, q_reg} + 33'd1) : {1'b0, q_reg};
    assign sum_new = k_reg[0] ? (sum_reg - $signed({1'b0, t_new}))
                              : (sum_reg + $signed({1'b0, t_new}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mat_pkg::EXP_IDLE;
        end else begin
            state_reg <= state_next;
        end
        f_reg   <= f_next;
        n_reg   <= n_next;
        t_reg   <= t_next;
        sum_reg <= sum_next;
        k_reg   <= k_next;
        v_reg   <= v_next;
        q_reg   <= q_next;
        p_reg   <= p_next;
    end

    always_comb begin
        state_next = state_reg;
        f_next     = f_reg;
        n_next     = n_reg;
        t_next     = t_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        v_next     = v_reg;
        q_next     = q_reg;
        p_next     = p_reg;
        op_a       = t_reg;
        op_b       = f_reg;
        case (state_reg)
            mat_pkg::EXP_IDLE: begin
                op_a = {1'b0, req.delta};
                op_b = {8'd0, inv_kt};
                if (req.start) begin
                    state_next = mat_pkg::EXP_XMUL;
                end
            end
            mat_pkg::EXP_XMUL: begin
                // integer part in [55:32], fraction in [31:0]
                if (prod_reg[55:32] >= mat_pkg::MAX_INT_PART) begin
                    p_next     = 33'd0;
                    state_next = mat_pkg::EXP_DONE;
                end else begin
                    f_next     = prod_reg[31:0];
                    n_next     = prod_reg[36:32];
                    t_next     = 33'h1_0000_0000;
                    sum_next   = 34'sh1_0000_0000;
                    k_next     = 4'd1;
                    state_next = mat_pkg::EXP_TERM;
                end
            end
            mat_pkg::EXP_TERM: begin
                op_a       = t_reg;
                op_b       = f_reg;
                state_next = mat_pkg::EXP_V;
            end
            mat_pkg::EXP_V: begin
                v_next     = prod_reg[63:32];
                op_a       = mat_pkg::recip_q32(k_reg);
                op_b       = prod_reg[63:32];
                state_next = mat_pkg::EXP_Q;
            end
            mat_pkg::EXP_Q: begin
                q_next     = prod_reg[63:32];
                op_a       = {29'd0, k_reg};
                op_b       = prod_reg[63:32];
                state_next = mat_pkg::EXP_C;
            end
            mat_pkg::EXP_C: begin
                t_next   = t_new;
                sum_next = sum_new;
                if (k_reg == mat_pkg::SERIES_TERMS) begin
                    p_next = sum_new[33] ? 33'd0 : sum_new[32:0];
                    if (n_reg == 5'd0) begin
                        state_next = mat_pkg::EXP_DONE;
                    end else begin
                        state_next = mat_pkg::EXP_POWM;
                    end
                end else begin
                    k_next     = k_reg + 4'd1;
                    state_next = mat_pkg::EXP_TERM;
                end
            end
            mat_pkg::EXP_POWM: begin
                op_a       = p_reg;
                op_b       = mat_pkg::EXP_M1_Q32;
                state_next = mat_pkg::EXP_POWR;
            end
            mat_pkg::EXP_POWR: begin
                p_next = prod_reg[64:32];
                n_next = n_reg - 5'd1;
                if (n_reg == 5'd1) begin
                    state_next = mat_pkg::EXP_DONE;
                end else begin
                    state_next = mat_pkg::EXP_POWM;
                end
            end
            mat_pkg::EXP_DONE: begin
                state_next = mat_pkg::EXP_IDLE;
            end
            default: begin
                state_next = mat_pkg::EXP_IDLE;
            end
        endcase
    end

    assign stat.done = (state_reg == mat_pkg::EXP_DONE);
    assign stat.prob = p_reg;

endmodule

/* rtl/metropolis_acceptance_tracker_core.sv */
// metropolis acceptance tracker: decision, run statistics and configuration
//
// Input beats on s_valid/s_ready carry a proposed Q16.16 score and a Q0.24
// random fraction; each beat yields exactly one result beat on m_valid/m_ready
// with the decision, the current score, the counters, the energy sum and the
// report and done flags. One item is in flight at a time: s_ready is high
// only while the sequencer is idle.
// Path from input beat to result: a done run goes straight to the result,
// a lower proposed score is accepted after the difference, floor(x) >= 17
// gives probability zero without the series, and otherwise n = floor(x) in
// 0..16 sets the work of the exponential: 13 series terms, each through the
// states TERM, V, Q and C on the one shared multiplier, then n powers of exp(-1).
// After each result is loaded the sequencer returns to idle, where it takes
// the next item.
// A result waits in the output register while m_ready is low; the next item
// may be accepted meanwhile but finishes only after that result is taken.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), to be
// used while the block is idle; writing start_score starts a new run.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// counters and the sum, and drops m_valid.
module metropolis_acceptance_tracker_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  mat_pkg::mat_in_t                        s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output mat_pkg::mat_out_t                       m_data,
    input  logic                                    cfg_we,
    input  logic [mat_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [31:0]                             cfg_wdata
);

    mat_pkg::mat_top_state_t state_reg, state_next;

    logic [23:0] inv_kt_reg;
    logic [31:0] lowest_energy_reg;
    logic [23:0] report_interval_reg;
    logic [31:0] target_reg;

    logic [31:0] score_now_reg, score_now_next;
    logic [31:0] step_count_reg, step_count_next;
    logic [31:0] accept_count_reg, accept_count_next;
    logic [31:0] bound_count_reg, bound_count_next;
    logic [63:0] score_acc_reg, score_acc_next;
    logic [23:0] interval_count_reg, interval_count_next;

    logic [31:0] prop_reg, prop_next;
    logic [23:0] rnd_reg, rnd_next;
    logic        acc_reg, acc_next;
    logic        skip_reg, skip_next;

    logic              m_valid_reg, m_valid_next;
    mat_pkg::mat_out_t m_data_reg, m_data_next;

    mat_pkg::mat_exp_req_t  exp_req;
    mat_pkg::mat_exp_stat_t exp_stat;

    logic [32:0] diff;
    logic [31:0] upd_score;
    logic [31:0] upd_accept;
    logic [31:0] upd_bound;
    logic [31:0] upd_step;
    logic [63:0] upd_acc;
    logic [23:0] ic_inc;
    logic        upd_rep;
    logic        out_load;

    mat_exp_engine u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (exp_req),
        .inv_kt  (inv_kt_reg),
        .stat    (exp_stat)
    );

    assign diff = {prop_reg[31], prop_reg} - {score_now_reg[31], score_now_reg};

    // statistics after the step now being finished
    assign upd_score  = acc_reg ? prop_reg : score_now_reg;
    assign upd_accept = acc_reg ? mat_pkg::sat_inc(accept_count_reg) : accept_count_reg;
    assign upd_bound  = (acc_reg && (prop_reg == lowest_energy_reg))
                        ? mat_pkg::sat_inc(bound_count_reg) : bound_count_reg;
    assign upd_step   = mat_pkg::sat_inc(step_count_reg);
    assign upd_acc    = score_acc_reg + {{32{upd_score[31]}}, upd_score};
    assign ic_inc     = interval_count_reg + 24'd1;
    assign upd_rep    = (ic_inc == report_interval_reg);

    assign out_load = (state_reg == mat_pkg::TOP_DEC) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_kt_reg          <= mat_pkg::INV_KT_RESET[23:0];
            lowest_energy_reg   <= 32'd0;
            report_interval_reg <= mat_pkg::REPORT_INTERVAL_RESET[23:0];
            target_reg          <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                // start score goes straight into the run state
                mat_pkg::CFG_START_SCORE: begin
                end
                mat_pkg::CFG_INV_KT:          inv_kt_reg          <= cfg_wdata[23:0];
                mat_pkg::CFG_LOWEST_ENERGY:   lowest_energy_reg   <= cfg_wdata;
                mat_pkg::CFG_REPORT_INTERVAL: report_interval_reg <= cfg_wdata[23:0];
                mat_pkg::CFG_TARGET_ACCEPTED: target_reg          <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= mat_pkg::TOP_IDLE;
            m_valid_reg        <= 1'b0;
            score_now_reg      <= 32'd0;
            step_count_reg     <= 32'd0;
            accept_count_reg   <= 32'd0;
            bound_count_reg    <= 32'd0;
            score_acc_reg      <= 64'd0;
            interval_count_reg <= 24'd0;
        end else begin
            state_reg          <= state_next;
            m_valid_reg        <= m_valid_next;
            score_now_reg      <= score_now_next;
            step_count_reg     <= step_count_next;
            accept_count_reg   <= accept_count_next;
            bound_count_reg    <= bound_count_next;
            score_acc_reg      <= score_acc_next;
            interval_count_reg <= interval_count_next;
        end
        prop_reg   <= prop_next;
        rnd_reg    <= rnd_next;
        acc_reg    <= acc_next;
        skip_reg   <= skip_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next          = state_reg;
        m_valid_next        = m_valid_reg;
        m_data_next         = m_data_reg;
        score_now_next      = score_now_reg;
        step_count_next     = step_count_reg;
        accept_count_next   = accept_count_reg;
        bound_count_next    = bound_count_reg;
        score_acc_next      = score_acc_reg;
        interval_count_next = interval_count_reg;
        prop_next           = prop_reg;
        rnd_next            = rnd_reg;
        acc_next            = acc_reg;
        skip_next           = skip_reg;
        exp_req.start       = 1'b0;
        exp_req.delta       = diff[31:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mat_pkg::TOP_IDLE: begin
                if (s_valid) begin
                    prop_next = s_data.proposed_score;
                    rnd_next  = s_data.rand_fraction;
                    acc_next  = 1'b0;
                    // run already done: the step leaves the state alone
                    skip_next = (accept_count_reg >= target_reg);
                    if (accept_count_reg >= target_reg) begin
                        state_next = mat_pkg::TOP_DEC;
                    end else begin
                        state_next = mat_pkg::TOP_DIFF;
                    end
                end
            end
            mat_pkg::TOP_DIFF: begin
                if (diff[32]) begin
                    acc_next   = 1'b1;
                    state_next = mat_pkg::TOP_DEC;
                end else begin
                    exp_req.start = 1'b1;
                    state_next    = mat_pkg::TOP_EXP;
                end
            end
            mat_pkg::TOP_EXP: begin
                if (exp_stat.done) begin
                    acc_next   = (exp_stat.prob[32:8] > {1'b0, rnd_reg});
                    state_next = mat_pkg::TOP_DEC;
                end
            end
            mat_pkg::TOP_DEC: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = mat_pkg::TOP_IDLE;
                    if (skip_reg) begin
                        m_data_next.accepted      = 1'b0;
                        m_data_next.current_score = score_now_reg;
                        m_data_next.step_total    = step_count_reg;
                        m_data_next.accept_total  = accept_count_reg;
                        m_data_next.bound_total   = bound_count_reg;
                        m_data_next.energy_sum    = score_acc_reg;
                        m_data_next.report        = 1'b0;
                        m_data_next.done_res      = 1'b1;
                    end else begin
                        score_now_next      = upd_score;
                        step_count_next     = upd_step;
                        accept_count_next   = upd_accept;
                        bound_count_next    = upd_bound;
                        score_acc_next      = upd_acc;
                        interval_count_next = upd_rep ? 24'd0 : ic_inc;
                        m_data_next.accepted      = acc_reg;
                        m_data_next.current_score = upd_score;
                        m_data_next.step_total    = upd_step;
                        m_data_next.accept_total  = upd_accept;
                        m_data_next.bound_total   = upd_bound;
                        m_data_next.energy_sum    = upd_acc;
                        m_data_next.report        = upd_rep;
                        m_data_next.done_res      = (upd_accept >= target_reg);
                    end
                end
            end
            default: begin
                state_next = mat_pkg::TOP_IDLE;
            end
        endcase

        // a new start score begins a new run
        if (cfg_we && (cfg_index == mat_pkg::CFG_START_SCORE)) begin
            score_now_next      = cfg_wdata;
            step_count_next     = 32'd0;
            accept_count_next   = 32'd0;
            bound_count_next    = 32'd0;
            score_acc_next      = 64'd0;
            interval_count_next = 24'd0;
        end
    end

    assign s_ready = (state_reg == mat_pkg::TOP_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_le_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_count_reg <= step_count_reg)
        else $error("accept count exceeds step count");

    a_bound_le_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        bound_count_reg <= accept_count_reg)
        else $error("bound count exceeds accept count");

    a_exp_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_stat.done |-> state_reg == mat_pkg::TOP_EXP)
        else $error("exponential finished outside its wait state");

    a_prob_range: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_stat.done |-> exp_stat.prob <= 33'h1_0000_0000)
        else $error("probability above one");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !skip_reg && upd_rep) |=> interval_count_reg == 24'd0)
        else $error("interval count not cleared on report");

endmodule
